FILE: hdl/buc_pkg.sv
`default_nettype none

package buc_pkg;

  // input beat operation codes
  typedef enum logic [1:0] {
    OP_RX      = 2'd0,
    OP_TXREADY = 2'd1,
    OP_WRITE   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_RX_OVF = 2'd1,
    ERR_TX_OVF = 2'd2,
    ERR_EMPTY  = 2'd3
  } err_t;

  // result of one beat, held between the ring update and the output register
  typedef struct packed {
    logic       line_valid;
    logic [7:0] line_byte;
    logic       line_from_ram;
    logic       read_valid;
    logic [7:0] rx_fill;
    logic [7:0] tx_fill;
    logic       tx_busy;
    err_t       error_code;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/buc_ram.sv
`default_nettype none

module buc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port that holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/buffered_uart_channel_unit.sv
`default_nettype none

// Buffered serial channel with a receive ring and a transmit ring of RING_DEPTH
// bytes each, both held in block RAM. Each input beat is one event: a received
// line byte, a transmitter-ready strobe, a host write or a host read, and it
// yields exactly one result beat with the line byte sent (if any), the byte
// read (if any), both fill levels, the transmitter busy mark and a status
// code. One beat is accepted every clock cycle unless out_ready holds the
// results; a result passes the s1 register, then the output register, with
// the RAM read registered alongside s1. Overflow drops the byte and reports
// it, an empty read reports it and does not wait; reset needs no clearing pass.
module buffered_uart_channel_unit #(
  parameter int RING_DEPTH = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_line_valid,
  output logic [7:0]      out_line_byte,
  output logic            out_read_valid,
  output logic [7:0]      out_read_byte,
  output logic [7:0]      out_rx_fill,
  output logic [7:0]      out_tx_fill,
  output logic            out_tx_busy,
  output logic [1:0]      out_error_code
);

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int FILL_X = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

  // ring control state
  logic [PTR_W-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [PTR_W-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [CNT_W-1:0] rx_count_r, rx_count_nxt, tx_count_r, tx_count_nxt;
  logic             tx_active_r, tx_active_nxt;

  // result pipeline
  buc_pkg::res_t s1_r, s1_nxt;
  logic          s1_v_r;
  logic          out_v_r;
  logic          out_line_valid_r, out_read_valid_r, out_tx_busy_r;
  logic [7:0]    out_line_byte_r, out_read_byte_r, out_rx_fill_r, out_tx_fill_r;
  logic [1:0]    out_error_code_r;

  logic accept, move;
  logic rx_we, rx_re, tx_we, tx_re;
  logic [7:0] rx_rdata, tx_rdata;
  logic [FILL_X-1:0] rx_fill_x, tx_fill_x;
  buc_pkg::op_t op;

  assign op       = buc_pkg::op_t'(in_op);
  assign move     = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || move;
  assign accept   = in_valid && in_ready;

  // ring rams
  buc_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head_r),
    .wdata (in_data_byte),
    .re    (rx_re),
    .raddr (rx_tail_r),
    .rdata (rx_rdata)
  );

  buc_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head_r),
    .wdata (in_data_byte),
    .re    (tx_re),
    .raddr (tx_tail_r),
    .rdata (tx_rdata)
  );

  // event decode and ring update
  always_comb begin
    rx_head_nxt   = rx_head_r;
    rx_tail_nxt   = rx_tail_r;
    rx_count_nxt  = rx_count_r;
    tx_head_nxt   = tx_head_r;
    tx_tail_nxt   = tx_tail_r;
    tx_count_nxt  = tx_count_r;
    tx_active_nxt = tx_active_r;
    rx_we = 1'b0;
    rx_re = 1'b0;
    tx_we = 1'b0;
    tx_re = 1'b0;
    s1_nxt = '0;
    s1_nxt.error_code = buc_pkg::ERR_OK;
    if (accept) begin
      unique case (op)
        buc_pkg::OP_RX: begin
          if (rx_count_r == CNT_FULL) begin
            s1_nxt.error_code = buc_pkg::ERR_RX_OVF;
          end else begin
            rx_we        = 1'b1;
            rx_head_nxt  = (rx_head_r == PTR_LAST) ? '0 : rx_head_r + 1'b1;
            rx_count_nxt = rx_count_r + 1'b1;
          end
        end
        buc_pkg::OP_TXREADY: begin
          if (tx_count_r == '0) begin
            tx_active_nxt = 1'b0;
          end else begin
            tx_re                = 1'b1;
            s1_nxt.line_valid    = 1'b1;
            s1_nxt.line_from_ram = 1'b1;
            tx_tail_nxt  = (tx_tail_r == PTR_LAST) ? '0 : tx_tail_r + 1'b1;
            tx_count_nxt = tx_count_r - 1'b1;
          end
        end
        buc_pkg::OP_WRITE: begin
          if (tx_active_r) begin
            if (tx_count_r == CNT_FULL) begin
              s1_nxt.error_code = buc_pkg::ERR_TX_OVF;
            end else begin
              tx_we        = 1'b1;
              tx_head_nxt  = (tx_head_r == PTR_LAST) ? '0 : tx_head_r + 1'b1;
              tx_count_nxt = tx_count_r + 1'b1;
            end
          end else begin
            s1_nxt.line_valid = 1'b1;
            s1_nxt.line_byte  = in_data_byte;
            tx_active_nxt     = 1'b1;
          end
        end
        buc_pkg::OP_READ: begin
          if (rx_count_r == '0) begin
            s1_nxt.error_code = buc_pkg::ERR_EMPTY;
          end else begin
            rx_re             = 1'b1;
            s1_nxt.read_valid = 1'b1;
            rx_tail_nxt  = (rx_tail_r == PTR_LAST) ? '0 : rx_tail_r + 1'b1;
            rx_count_nxt = rx_count_r - 1'b1;
          end
        end
        default: begin
          s1_nxt.error_code = buc_pkg::ERR_OK;
        end
      endcase
    end
    rx_fill_x      = FILL_X'(rx_count_nxt);
    tx_fill_x      = FILL_X'(tx_count_nxt);
    s1_nxt.rx_fill = rx_fill_x[7:0];
    s1_nxt.tx_fill = tx_fill_x[7:0];
    s1_nxt.tx_busy = tx_active_nxt;
  end

  // ring state and result pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      rx_count_r  <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      tx_count_r  <= '0;
      tx_active_r <= 1'b0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      rx_head_r   <= rx_head_nxt;
      rx_tail_r   <= rx_tail_nxt;
      rx_count_r  <= rx_count_nxt;
      tx_head_r   <= tx_head_nxt;
      tx_tail_r   <= tx_tail_nxt;
      tx_count_r  <= tx_count_nxt;
      tx_active_r <= tx_active_nxt;
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (move) begin
        s1_v_r <= 1'b0;
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers, ram data merged on the way to the output
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (move) begin
      out_line_valid_r <= s1_r.line_valid;
      out_line_byte_r  <= s1_r.line_from_ram ? tx_rdata : s1_r.line_byte;
      out_read_valid_r <= s1_r.read_valid;
      out_read_byte_r  <= s1_r.read_valid ? rx_rdata : 8'd0;
      out_rx_fill_r    <= s1_r.rx_fill;
      out_tx_fill_r    <= s1_r.tx_fill;
      out_tx_busy_r    <= s1_r.tx_busy;
      out_error_code_r <= s1_r.error_code;
    end
  end

  assign out_valid      = out_v_r;
  assign out_line_valid = out_line_valid_r;
  assign out_line_byte  = out_line_byte_r;
  assign out_read_valid = out_read_valid_r;
  assign out_read_byte  = out_read_byte_r;
  assign out_rx_fill    = out_rx_fill_r;
  assign out_tx_fill    = out_tx_fill_r;
  assign out_tx_busy    = out_tx_busy_r;
  assign out_error_code = out_error_code_r;

endmodule

`default_nettype wire
